>>> hw/rtl/sgm_pkg.sv
// shared types, constants and codes for the servo group move framer
// no dependencies; the framer, front and back refer to it by scoped names
package sgm_pkg;

  localparam int unsigned MAX_SERVOS  = 32;
  localparam int unsigned FRAME_BYTES = 103;
  localparam int unsigned HDR_BYTES   = 7;
  localparam int unsigned SLOT_COUNT  = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  // largest count whose frame still fits a slot
  localparam int unsigned FIT_SERVOS  = (FRAME_BYTES - HDR_BYTES) / 3;
  localparam int unsigned COUNT_MAX   = (FIT_SERVOS < MAX_SERVOS) ? FIT_SERVOS : MAX_SERVOS;

  localparam int unsigned CNT_W   = $clog2(MAX_SERVOS + 1);
  localparam int unsigned ENT_W   = $clog2(MAX_SERVOS);
  localparam int unsigned RAM_DEPTH = SLOT_COUNT * MAX_SERVOS;
  localparam int unsigned RAM_AW  = $clog2(RAM_DEPTH);
  localparam int unsigned RAM_W   = 24;
  localparam int unsigned POS_W   = $clog2(HDR_BYTES + 1);

  localparam logic [1:0] NO_SLOT = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_HEADER  = 2'd0;
  localparam logic [1:0] REG_COMMAND = 2'd1;
  localparam logic [1:0] REG_POS_LIM = 2'd2;
  localparam logic [1:0] REG_T_FLOOR = 2'd3;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_SLOT  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_STARTED  = 3'd1,
    ST_QUEUED   = 3'd2,
    ST_REJECTED = 3'd3,
    ST_IGNORED  = 3'd4,
    ST_IDLE     = 3'd5
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  servo_count;
    logic [15:0] move_time;
    logic [7:0]  servo_id;
    logic [15:0] target_position;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_frame_end;
    status_e     status;
  } out_item_t;

  // entry word request to the frame store
  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] waddr;
    logic [RAM_W-1:0]  wdata;
    logic              re;
    logic [RAM_AW-1:0] raddr;
  } ram_req_t;

  // classified result handed from front to back
  typedef struct packed {
    status_e     status;
    logic        tx_valid;
    logic        frame_end;
    logic        from_ram;
    logic [1:0]  sub;
    logic [7:0]  hdr_data;
  } desc_t;

endpackage

>>> hw/rtl/servo_group_move_framer.sv
// path: an accepted item's result is registered in the join stage, then queued
// throughput: one item per cycle while the result queue has room; the front updates
// all slot state in the accept cycle, and the entry store read is registered ahead of the queue
// a four-deep result queue lets the output stall while input keeps flowing until it fills
// reset: asynchronous, active low; registers back to defaults, no frame open, line idle
// the entry store holds no reset state and needs no clearing pass
module servo_group_move_framer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sgm_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sgm_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);

  sgm_pkg::ram_req_t ram_req;
  sgm_pkg::desc_t    desc;
  logic              desc_valid;
  logic              back_full;
  logic [sgm_pkg::RAM_W-1:0] ram_rdata;

  // input holds off only while the result queue has no room
  assign in_stall_o = back_full;

  // front: classifies each item, owns the slot pointers and header fields
  sgm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (back_full),
    .in_item_i    (in_item_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .ram_req_o    (ram_req),
    .desc_valid_o (desc_valid),
    .desc_o       (desc)
  );

  // entry store: one 24-bit word (id, position low, position high) per servo per slot
  sgm_ram #(
    .WIDTH (sgm_pkg::RAM_W),
    .DEPTH (sgm_pkg::RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // back: picks the byte and queues the result item
  sgm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_i       (desc),
    .rdata_i      (ram_rdata),
    .full_o       (back_full),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

>>> hw/rtl/sgm_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module sgm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sgm_front.sv
// front part: config registers, slot bookkeeping, frame store requests
// depends on sgm_pkg
module sgm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  sgm_pkg::in_item_t in_item_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  output sgm_pkg::ram_req_t ram_req_o,
  output logic              desc_valid_o,
  output sgm_pkg::desc_t    desc_o
);

  logic [7:0]  header_q, command_q;
  logic [15:0] pos_lim_q, t_floor_q;

  logic [1:0] staging_q, staging_d;
  logic [1:0] active_q, active_d;
  logic [1:0] pending_q, pending_d;
  logic       building_q, building_d;
  logic [sgm_pkg::CNT_W-1:0] exp_q, exp_d;
  logic [sgm_pkg::CNT_W-1:0] rcv_q, rcv_d;
  logic [sgm_pkg::POS_W-1:0] pos_q, pos_d;
  logic [sgm_pkg::ENT_W-1:0] ent_q, ent_d;
  logic [1:0] sub_q, sub_d;

  // per-slot header fields, written at begin
  logic [7:0]  s_hdr_q [sgm_pkg::SLOT_COUNT];
  logic [7:0]  s_cmd_q [sgm_pkg::SLOT_COUNT];
  logic [sgm_pkg::CNT_W-1:0] s_n_q [sgm_pkg::SLOT_COUNT];
  logic [15:0] s_time_q [sgm_pkg::SLOT_COUNT];
  logic        slot_we;

  logic        accept;
  logic [7:0]  cnt_in;
  logic [15:0] t_eff, p_eff;
  logic [1:0]  act_idx;
  logic [sgm_pkg::CNT_W-1:0] rcv_inc;
  logic [sgm_pkg::CNT_W-1:0] n_act;
  logic [7:0]  len_byte;
  logic        at_last;
  sgm_pkg::desc_t    desc;
  sgm_pkg::ram_req_t req;

  function automatic logic [1:0] free_slot(logic [1:0] act, logic [1:0] pend);
    logic [1:0] res;
    res = 2'd0;
    for (int s = sgm_pkg::SLOT_COUNT - 1; s >= 0; s--) begin
      if (2'(s) != act && 2'(s) != pend) begin
        res = 2'(s);
      end
    end
    return res;
  endfunction

  assign accept  = in_valid_i && !in_stall_i;
  assign cnt_in  = in_item_i.servo_count;
  assign t_eff   = (in_item_i.move_time < t_floor_q) ? t_floor_q : in_item_i.move_time;
  assign p_eff   = (in_item_i.target_position > pos_lim_q) ? pos_lim_q
                                                           : in_item_i.target_position;
  assign act_idx = (active_q == sgm_pkg::NO_SLOT) ? 2'd0 : active_q;
  assign rcv_inc = rcv_q + 1'b1;
  assign n_act   = s_n_q[act_idx];
  assign len_byte = 8'({n_act, 1'b0}) + 8'(n_act) + 8'd5;
  assign at_last = (pos_q == sgm_pkg::POS_W'(sgm_pkg::HDR_BYTES)) && (sub_q == 2'd2) &&
                   (ent_q == sgm_pkg::ENT_W'(n_act - 1'b1));

  always_comb begin
    staging_d  = staging_q;
    active_d   = active_q;
    pending_d  = pending_q;
    building_d = building_q;
    exp_d      = exp_q;
    rcv_d      = rcv_q;
    pos_d      = pos_q;
    ent_d      = ent_q;
    sub_d      = sub_q;
    slot_we    = 1'b0;
    desc       = '0;
    desc.status = sgm_pkg::ST_OK;
    req        = '0;
    req.waddr  = sgm_pkg::RAM_AW'(staging_q * sgm_pkg::MAX_SERVOS) +
                 sgm_pkg::RAM_AW'(rcv_q[sgm_pkg::ENT_W-1:0]);
    req.wdata  = {p_eff, in_item_i.servo_id};
    req.raddr  = sgm_pkg::RAM_AW'(act_idx * sgm_pkg::MAX_SERVOS) + sgm_pkg::RAM_AW'(ent_q);
    if (accept) begin
      unique case (in_item_i.kind)
        sgm_pkg::KIND_BEGIN: begin
          if (cnt_in < 8'd1 || cnt_in > 8'(sgm_pkg::COUNT_MAX)) begin
            desc.status = sgm_pkg::ST_REJECTED;
          end else begin
            slot_we    = 1'b1;
            exp_d      = sgm_pkg::CNT_W'(cnt_in);
            rcv_d      = '0;
            building_d = 1'b1;
          end
        end
        sgm_pkg::KIND_ENTRY: begin
          if (!building_q) begin
            desc.status = sgm_pkg::ST_IGNORED;
          end else begin
            req.we = 1'b1;
            rcv_d  = rcv_inc;
            if (rcv_inc >= exp_q) begin
              building_d = 1'b0;
              if (active_q == sgm_pkg::NO_SLOT) begin
                active_d    = staging_q;
                pos_d       = '0;
                ent_d       = '0;
                sub_d       = '0;
                desc.status = sgm_pkg::ST_STARTED;
                staging_d   = free_slot(staging_q, pending_q);
              end else begin
                pending_d   = staging_q;
                desc.status = sgm_pkg::ST_QUEUED;
                staging_d   = free_slot(active_q, staging_q);
              end
            end
          end
        end
        sgm_pkg::KIND_SLOT: begin
          if (active_q == sgm_pkg::NO_SLOT) begin
            desc.status = sgm_pkg::ST_IDLE;
          end else begin
            desc.tx_valid = 1'b1;
            desc.sub      = sub_q;
            if (pos_q < sgm_pkg::POS_W'(sgm_pkg::HDR_BYTES)) begin
              unique case (pos_q)
                3'd0, 3'd1: desc.hdr_data = s_hdr_q[act_idx];
                3'd2:       desc.hdr_data = len_byte;
                3'd3:       desc.hdr_data = s_cmd_q[act_idx];
                3'd4:       desc.hdr_data = 8'(n_act);
                3'd5:       desc.hdr_data = s_time_q[act_idx][7:0];
                3'd6:       desc.hdr_data = s_time_q[act_idx][15:8];
                default:    desc.hdr_data = '0;
              endcase
              pos_d = pos_q + 1'b1;
            end else begin
              desc.from_ram = 1'b1;
              req.re        = 1'b1;
              if (at_last) begin
                desc.frame_end = 1'b1;
                pos_d = '0;
                ent_d = '0;
                sub_d = '0;
                if (pending_q != sgm_pkg::NO_SLOT) begin
                  active_d    = pending_q;
                  pending_d   = sgm_pkg::NO_SLOT;
                  desc.status = sgm_pkg::ST_STARTED;
                end else begin
                  active_d = sgm_pkg::NO_SLOT;
                end
              end else if (sub_q == 2'd2) begin
                sub_d = '0;
                ent_d = ent_q + 1'b1;
              end else begin
                sub_d = sub_q + 1'b1;
              end
            end
          end
        end
        sgm_pkg::KIND_NONE: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q   <= 8'h55;
      command_q  <= 8'h03;
      pos_lim_q  <= 16'd1000;
      t_floor_q  <= 16'd20;
      staging_q  <= 2'd0;
      active_q   <= sgm_pkg::NO_SLOT;
      pending_q  <= sgm_pkg::NO_SLOT;
      building_q <= 1'b0;
      exp_q      <= '0;
      rcv_q      <= '0;
      pos_q      <= '0;
      ent_q      <= '0;
      sub_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sgm_pkg::REG_HEADER:  header_q  <= cfg_data_i[7:0];
          sgm_pkg::REG_COMMAND: command_q <= cfg_data_i[7:0];
          sgm_pkg::REG_POS_LIM: pos_lim_q <= cfg_data_i;
          sgm_pkg::REG_T_FLOOR: t_floor_q <= cfg_data_i;
        endcase
      end
      staging_q  <= staging_d;
      active_q   <= active_d;
      pending_q  <= pending_d;
      building_q <= building_d;
      exp_q      <= exp_d;
      rcv_q      <= rcv_d;
      pos_q      <= pos_d;
      ent_q      <= ent_d;
      sub_q      <= sub_d;
    end
  end

  // slot header payload, no reset
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      s_hdr_q[staging_q]  <= header_q;
      s_cmd_q[staging_q]  <= command_q;
      s_n_q[staging_q]    <= sgm_pkg::CNT_W'(cnt_in);
      s_time_q[staging_q] <= t_eff;
    end
  end

  assign ram_req_o    = req;
  assign desc_valid_o = accept;
  assign desc_o       = desc;

endmodule

>>> hw/rtl/sgm_back.sv
// back part: joins store read data with the descriptor, result queue, output
// depends on sgm_pkg
module sgm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 desc_valid_i,
  input  sgm_pkg::desc_t       desc_i,
  input  logic [sgm_pkg::RAM_W-1:0] rdata_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sgm_pkg::out_item_t   out_item_o
);

  localparam int unsigned PTR_W = $clog2(sgm_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(sgm_pkg::QUEUE_DEPTH + 1);

  logic           s1_valid_q;
  sgm_pkg::desc_t s1_desc_q;

  sgm_pkg::out_item_t q_mem_q [sgm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  sgm_pkg::out_item_t push_item;
  logic [7:0] ram_byte;
  logic push, pop;

  always_comb begin
    unique case (s1_desc_q.sub)
      2'd0:    ram_byte = rdata_i[7:0];
      2'd1:    ram_byte = rdata_i[15:8];
      default: ram_byte = rdata_i[23:16];
    endcase
  end

  always_comb begin
    push_item.tx_valid     = s1_desc_q.tx_valid;
    push_item.tx_byte      = s1_desc_q.from_ram ? ram_byte : s1_desc_q.hdr_data;
    push_item.tx_frame_end = s1_desc_q.frame_end;
    push_item.status       = s1_desc_q.status;
  end

  assign push  = s1_valid_q;
  assign pop   = (cnt_q != '0) && !out_stall_i;
  assign cnt_d = cnt_q + CNT_W'(push) - CNT_W'(pop);

  // room for the queued items plus the one in the join stage
  assign full_o = (cnt_q + CNT_W'(s1_valid_q)) >= CNT_W'(sgm_pkg::QUEUE_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wptr_q     <= '0;
      rptr_q     <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= desc_valid_i;
      cnt_q      <= cnt_d;
      if (push) begin
        wptr_q <= (wptr_q == PTR_W'(sgm_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PTR_W'(sgm_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_valid_i) begin
      s1_desc_q <= desc_i;
    end
    if (push) begin
      q_mem_q[wptr_q] <= push_item;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = q_mem_q[rptr_q];

endmodule
